FILE: sv/wmwf_pkg.sv
// Package for the weighted min-window filter: widths, codes and states.
// Used by wmwf_div and weighted_min_window_filter_top; depends on nothing.
`default_nettype none
package wmwf_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned MaxRadius = 7;
  localparam int unsigned ColW = 24;
  localparam int unsigned WgtW = 16;
  localparam int unsigned NrmW = ColW + 12;
  localparam int unsigned DimW = 9;

  typedef enum logic {
    CmdStore = 1'b0,
    CmdQuery = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    RegRadius = 2'd0,
    RegWidth  = 2'd1,
    RegHeight = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StCenter,
    StCenterWait,
    StNbrAddr,
    StNbrWait,
    StDivStart,
    StDivRun,
    StNext,
    StMul,
    StMulWait,
    StDone
  } state_e;
endpackage
`default_nettype wire

FILE: sv/wmwf_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses wmwf_pkg for widths; zero divisor returns zero.
`default_nettype none
module wmwf_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [wmwf_pkg::NrmW-1:0]   dividend_i,
  input  wire logic [wmwf_pkg::WgtW-1:0]   divisor_i,
  output logic                             done_o,
  output logic [wmwf_pkg::NrmW-1:0]        quot_o
);
  localparam int unsigned N  = wmwf_pkg::NrmW;
  localparam int unsigned CW = $clog2(N + 1);

  logic [N-1:0]                quot_q, quot_d;
  logic [wmwf_pkg::WgtW:0]     rem_q, rem_d;
  logic [wmwf_pkg::WgtW-1:0]   dvs_q;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;
  logic [wmwf_pkg::WgtW+1:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CW'(N);
      busy_d = (divisor_i != '0);
      done_d = (divisor_i == '0);
      if (divisor_i == '0) quot_d = '0;
    end else if (busy_q) begin
      trial = {rem_q, quot_q[N-1]} - {2'b00, dvs_q};
      if (!trial[wmwf_pkg::WgtW+1]) begin
        rem_d  = trial[wmwf_pkg::WgtW:0];
        quot_d = {quot_q[N-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[wmwf_pkg::WgtW-1:0], quot_q[N-1]};
        quot_d = {quot_q[N-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) dvs_q <= divisor_i;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && divisor_i != '0) |=> busy_q) else $error("divider not started");
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && divisor_i == '0) |=> (done_q && quot_q == '0))
    else $error("zero divisor not zero");
`endif
endmodule
`default_nettype wire

FILE: sv/weighted_min_window_filter_top.sv
// Top level of the weighted min-window filter: pixel memory, sequencer, one
// shared divider and one multiplier. Depends on wmwf_pkg and wmwf_div.
//
//  channel | direction | handshake             | beat
//  command | in        | start / busy          | command, pos, colours, weight
//  result  | out       | done_o strobe         | pos out, filtered colours
//  config  | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//
// A query with radius r visits (2r+1)^2 window positions: each one in the image
// takes a memory read and three divisions, one per colour; then three multiplies.
// Radius 0 returns the centre colours without divisions. The divider sets the rate.
// No clearing pass after reset. Results are flagged by done_o for one cycle and
// cannot be stalled.
`default_nettype none
module weighted_min_window_filter_top #(
  parameter int unsigned MAX_WIDTH  = wmwf_pkg::MaxWidth,
  parameter int unsigned MAX_HEIGHT = wmwf_pkg::MaxHeight,
  parameter int unsigned MAX_RADIUS = wmwf_pkg::MaxRadius
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       command_i,
  input  wire logic [7:0]                 pos_x_i,
  input  wire logic [7:0]                 pos_y_i,
  input  wire logic [wmwf_pkg::ColW-1:0]  red_in_i,
  input  wire logic [wmwf_pkg::ColW-1:0]  green_in_i,
  input  wire logic [wmwf_pkg::ColW-1:0]  blue_in_i,
  input  wire logic [wmwf_pkg::WgtW-1:0]  weight_in_i,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [wmwf_pkg::DimW-1:0]  cfg_data_i,
  output logic                            done_o,
  output logic [7:0]                      pos_x_out_o,
  output logic [7:0]                      pos_y_out_o,
  output logic [wmwf_pkg::ColW-1:0]       red_out_o,
  output logic [wmwf_pkg::ColW-1:0]       green_out_o,
  output logic [wmwf_pkg::ColW-1:0]       blue_out_o
);
  localparam int unsigned CW   = wmwf_pkg::ColW;
  localparam int unsigned WW   = wmwf_pkg::WgtW;
  localparam int unsigned NW   = wmwf_pkg::NrmW;
  localparam int unsigned XW   = (MAX_WIDTH > 256) ? 8 :
                                 (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW   = (MAX_HEIGHT > 256) ? 8 :
                                 (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW   = XW + YW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned RW   = $clog2(MAX_RADIUS + 2) + 1;
  localparam int unsigned SW   = 10;
  localparam int unsigned EW   = 3 * CW + WW;

  typedef logic [wmwf_pkg::DimW-1:0] dim_t;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] raddr;
  logic          rd_en, wr_en;

  logic [2:0]      radius_q;
  dim_t width_q, height_q;

  wmwf_pkg::state_e st_q, st_d;
  logic [7:0]        x_q, y_q;
  logic signed [SW-1:0] nx_q, nx_d, ny_q, ny_d;
  logic signed [RW-1:0] rad_q;
  logic [WW-1:0]     cw_q;
  logic [NW-1:0]     mn_q [3];
  logic [1:0]        ch_q, ch_d;
  logic [NW+WW-1:0]  prod_q;
  logic              div_start;
  logic [NW-1:0]     div_dvd, div_quot;
  logic              div_done;
  logic              res_v_q;
  logic [CW-1:0]     res_q [3];

  // effective dimensions
  dim_t ew, eh;
  always_comb begin
    ew = (width_q == '0) ? dim_t'(1) :
         (32'(width_q) > MAX_WIDTH) ? dim_t'(MAX_WIDTH) : width_q;
    eh = (height_q == '0) ? dim_t'(1) :
         (32'(height_q) > MAX_HEIGHT) ? dim_t'(MAX_HEIGHT) : height_q;
  end

  logic inside_in;
  assign inside_in = ({1'b0, pos_x_i} < ew) && ({1'b0, pos_y_i} < eh);
  logic accept;
  assign accept = start && !busy;
  assign busy = (st_q != wmwf_pkg::StIdle);
  assign cfg_ready_o = !busy;

  assign wr_en = accept && (command_i == wmwf_pkg::CmdStore) && inside_in;
  logic nb_in;
  assign nb_in = (nx_q >= 0) && (ny_q >= 0) &&
                 (nx_q < $signed({1'b0, ew})) && (ny_q < $signed({1'b0, eh}));

  always_comb begin
    raddr = {y_q[YW-1:0], x_q[XW-1:0]};
    if (st_q == wmwf_pkg::StNbrAddr)
      raddr = {ny_q[YW-1:0], nx_q[XW-1:0]};
  end
  assign rd_en = (st_q == wmwf_pkg::StCenter) || (st_q == wmwf_pkg::StNbrAddr);

  always_ff @(posedge clk_i) begin
    if (wr_en)
      mem[{pos_y_i[YW-1:0], pos_x_i[XW-1:0]}] <=
        {red_in_i, green_in_i, blue_in_i, weight_in_i};
    if (rd_en) rd_q <= mem[raddr];
  end

  logic [CW-1:0] rd_col [3];
  assign rd_col[0] = rd_q[EW-1 -: CW];
  assign rd_col[1] = rd_q[EW-1-CW -: CW];
  assign rd_col[2] = rd_q[EW-1-2*CW -: CW];
  assign div_dvd = {rd_col[ch_q], 12'd0};

  wmwf_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (rd_q[WW-1:0]),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  logic last_x, last_y;
  assign last_x = (nx_q == $signed(SW'(x_q)) + SW'(rad_q));
  assign last_y = (ny_q == $signed(SW'(y_q)) + SW'(rad_q));

  always_comb begin
    st_d = st_q;
    nx_d = nx_q;
    ny_d = ny_q;
    ch_d = ch_q;
    div_start = 1'b0;
    case (st_q)
      wmwf_pkg::StIdle: begin
        if (accept && command_i == wmwf_pkg::CmdQuery)
          st_d = inside_in ? wmwf_pkg::StCenter : wmwf_pkg::StDone;
      end
      wmwf_pkg::StCenter: st_d = wmwf_pkg::StCenterWait;
      wmwf_pkg::StCenterWait: begin
        nx_d = $signed(SW'(x_q)) - SW'(rad_q);
        ny_d = $signed(SW'(y_q)) - SW'(rad_q);
        st_d = (rad_q == '0) ? wmwf_pkg::StDone : wmwf_pkg::StNext;
        if (rad_q != '0) begin
          st_d = wmwf_pkg::StNbrAddr;
          nx_d = $signed(SW'(x_q)) - SW'(rad_q);
        end
      end
      wmwf_pkg::StNbrAddr: begin
        ch_d = 2'd0;
        st_d = nb_in ? wmwf_pkg::StNbrWait : wmwf_pkg::StNext;
      end
      wmwf_pkg::StNbrWait: st_d = wmwf_pkg::StDivStart;
      wmwf_pkg::StDivStart: begin
        div_start = 1'b1;
        st_d = wmwf_pkg::StDivRun;
      end
      wmwf_pkg::StDivRun: begin
        if (div_done) begin
          if (ch_q == 2'd2) st_d = wmwf_pkg::StNext;
          else begin
            ch_d = ch_q + 2'd1;
            st_d = wmwf_pkg::StDivStart;
          end
        end
      end
      wmwf_pkg::StNext: begin
        if (last_x) begin
          nx_d = $signed(SW'(x_q)) - SW'(rad_q);
          ny_d = ny_q + SW'(1);
          if (last_y) begin
            st_d = wmwf_pkg::StMul;
            ch_d = 2'd0;
          end else st_d = wmwf_pkg::StNbrAddr;
        end else begin
          nx_d = nx_q + SW'(1);
          st_d = wmwf_pkg::StNbrAddr;
        end
      end
      wmwf_pkg::StMul: st_d = wmwf_pkg::StMulWait;
      wmwf_pkg::StMulWait: begin
        if (ch_q == 2'd2) st_d = wmwf_pkg::StDone;
        else begin
          ch_d = ch_q + 2'd1;
          st_d = wmwf_pkg::StMul;
        end
      end
      wmwf_pkg::StDone: st_d = wmwf_pkg::StIdle;
      default: st_d = wmwf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= wmwf_pkg::StIdle;
      radius_q <= '0;
      width_q  <= dim_t'(256);
      height_q <= dim_t'(256);
      res_v_q  <= 1'b0;
      ch_q     <= '0;
    end else begin
      st_q    <= st_d;
      ch_q    <= ch_d;
      res_v_q <= (st_q == wmwf_pkg::StDone);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          wmwf_pkg::RegRadius: radius_q <= cfg_data_i[2:0];
          wmwf_pkg::RegWidth:  width_q  <= cfg_data_i;
          wmwf_pkg::RegHeight: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  logic [CW-1:0] sat;
  assign sat = (prod_q[NW+WW-1:12+CW] != '0) ? {CW{1'b1}} : prod_q[12+CW-1:12];

  always_ff @(posedge clk_i) begin
    nx_q <= nx_d;
    ny_q <= ny_d;
    if (accept) begin
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      rad_q <= (32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);
      res_q[0] <= '0;
      res_q[1] <= '0;
      res_q[2] <= '0;
    end
    if (st_q == wmwf_pkg::StCenterWait) begin
      cw_q <= rd_q[WW-1:0];
      mn_q[0] <= '1;
      mn_q[1] <= '1;
      mn_q[2] <= '1;
      if (rad_q == '0) begin
        res_q[0] <= rd_col[0];
        res_q[1] <= rd_col[1];
        res_q[2] <= rd_col[2];
      end
    end
    if (st_q == wmwf_pkg::StDivRun && div_done && div_quot < mn_q[ch_q])
      mn_q[ch_q] <= div_quot;
    if (st_q == wmwf_pkg::StMul) prod_q <= mn_q[ch_q] * cw_q;
    if (st_q == wmwf_pkg::StMulWait) res_q[ch_q] <= sat;
  end

  assign done_o      = res_v_q;
  assign pos_x_out_o = x_q;
  assign pos_y_out_o = y_q;
  assign red_out_o   = res_q[0];
  assign green_out_o = res_q[1];
  assign blue_out_o  = res_q[2];

`ifndef SYNTHESIS
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (st_q == wmwf_pkg::StIdle)) else $error("write while busy");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (st_q == wmwf_pkg::StDivRun)) else $error("divider lost");
`endif
endmodule
`default_nettype wire
